// ===== design/asu_pkg.sv =====
// Shared types and constants for the Adam / SGD parameter update block.
// Used by the controller, datapath, top level and bench; no dependencies of its own.
package asu_pkg;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [30:0] BETA1   = 31'd1932735283;
  localparam logic [30:0] BETA2   = 31'd2145336164;
  localparam logic [31:0] OMB1    = 32'd214748365;
  localparam logic [31:0] OMB2    = 32'd2147484;

  localparam logic [23:0] RST_LR  = 24'd16777;
  localparam logic [31:0] RST_EPS = 32'd43;

  localparam logic [1:0] REG_OPT = 2'd0;
  localparam logic [1:0] REG_LR  = 2'd1;
  localparam logic [1:0] REG_EPS = 2'd2;

  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE, OP_PW1M, OP_PW1U, OP_PW2M, OP_PW2U, OP_SGDM, OP_SGDU,
    OP_M1, OP_M2, OP_MU, OP_SQM, OP_SQU, OP_V1, OP_V2, OP_VU,
    OP_DM, OP_MHU, OP_DV, OP_VHU, OP_SQS, OP_DENU, OP_STM, OP_DS, OP_PU,
    OP_WBL, OP_WBS, OP_WBA, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_PW1M, S_PW1U, S_PW2M, S_PW2U, S_SGDM, S_SGDU,
    S_M1, S_M2, S_MU, S_SQM, S_SQU, S_V1, S_V2, S_VU,
    S_DM, S_DMW, S_MHU, S_DV, S_DVW, S_VHU, S_SQS, S_SQW, S_DENU,
    S_STM, S_DS, S_DSW, S_PU, S_WBL, S_WBS, S_WBA, S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic sel;
    logic capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic mode;
    logic begin_pass;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

// ===== design/asu_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 34 quotient bits.
// Flags overflow when the quotient does not fit; no package dependencies.
module asu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [40:0] den,
  output logic        done,
  output logic [33:0] quo,
  output logic        ovf
);

  localparam int unsigned STEPS = 34;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [40:0] rem_r;
  logic [33:0] low_r;
  logic [33:0] quo_r;
  logic [40:0] den_r;
  logic        ovf_r;
  logic [41:0] trial;
  logic [41:0] diff;
  logic        ge;
  logic [40:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, low_r[33]};
    ge      = trial >= {1'b0, den_r};
    diff    = trial - {1'b0, den_r};
    rem_nxt = ge ? diff[40:0] : trial[40:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {11'd0, num[63:34]};
      low_r <= num[33:0];
      den_r <= den;
      ovf_r <= {11'd0, num[63:34]} >= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[32:0], 1'b0};
      quo_r <= {quo_r[32:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

// ===== design/asu_sqrt.sv =====
// Bit-pair integer square root of rad * 2^32, one result bit per cycle.
// Standalone unit; no package dependencies.
module asu_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] rad,
  output logic        done,
  output logic [31:0] root
);

  localparam int unsigned STEPS = 32;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [63:0] rad_r;
  logic [34:0] rem2;
  logic [34:0] trial;
  logic        ge;

  always_comb begin
    rem2  = {rem_r[32:0], rad_r[63:62]};
    trial = {1'b0, root_r, 2'b01};
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      root_r <= '0;
      rad_r  <= {rad, 32'd0};
    end else if (busy_r) begin
      rem_r  <= ge ? (rem2 - trial) : rem2;
      root_r <= {root_r[30:0], ge};
      rad_r  <= {rad_r[61:0], 2'b00};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/asu_dp.sv =====
// Datapath: parameter and moment memories, shared multiplier, divider and root units.
// Depends on asu_pkg, asu_div and asu_sqrt; driven by asu_ctrl commands.
module asu_dp #(
  parameter int unsigned FEATURE_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  asu_pkg::cmd_t      cmd,
  output asu_pkg::sts_t      sts,
  input  logic               in_mode,
  input  logic [7:0]         in_feature_index,
  input  logic               in_begin_pass,
  input  logic signed [31:0] in_gamma_operand,
  input  logic signed [31:0] in_beta_operand,
  input  logic [23:0]        cfg_lr,
  input  logic [31:0]        cfg_eps,
  output logic [7:0]         out_index,
  output logic signed [31:0] out_new_gamma,
  output logic signed [31:0] out_new_beta
);

  localparam int unsigned DEPTH = (FEATURE_COUNT > 256) ? 256 : FEATURE_COUNT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [63:0]  par_mem [DEPTH];
  logic [127:0] mom_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  logic [7:0]         idx_r;
  logic [AW-1:0]      addr_r;
  logic               mode_r, begin_r, rng_r;
  logic signed [31:0] gop_r, bop_r;
  logic [63:0]        par_rd_r;
  logic [127:0]       mom_rd_r;
  logic               mvld_r;
  logic [31:0]        p1_r, p2_r;
  logic signed [65:0] prod_r, acc_r;
  logic signed [31:0] mn_r;
  logic [31:0]        sq_r, vn_r, vh_r;
  logic [30:0]        mh_r;
  logic [40:0]        den_r;
  logic signed [31:0] pn_r [2];
  logic signed [31:0] mw_r [2];
  logic [31:0]        vw_r [2];
  logic signed [31:0] res_r [2];
  logic [7:0]         oidx_r;
  logic signed [31:0] og_r, ob_r;

  logic [AW-1:0]      in_addr;
  logic               in_rng;
  logic signed [31:0] g, p, m;
  logic [31:0]        v;
  logic signed [32:0] gx, ag, mnx;
  logic [31:0]        am;
  logic [31:0]        d1, d2;
  logic signed [32:0] mul_a, mul_b;
  logic signed [66:0] sum, sum_rnd, m_sh;
  logic signed [31:0] m_nxt;
  logic [62:0]        sq_t;
  logic [31:0]        sq_nxt, v_nxt, vh_nxt;
  logic [30:0]        mh_nxt;
  logic signed [65:0] sgd_rnd;
  logic signed [34:0] sgd_sum, pu_sum;
  logic [33:0]        step;
  logic               div_start, div_done, div_ovf;
  logic [63:0]        div_num;
  logic [40:0]        div_den;
  logic [33:0]        div_quo;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (!x[34] && (|x[33:31])) r = 32'sh7FFF_FFFF;
    else if (x[34] && !(&x[33:31])) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  assign in_addr = in_feature_index[AW-1:0];
  assign in_rng  = ({24'd0, in_feature_index} < 32'(FEATURE_COUNT));

  always_comb begin
    g   = cmd.sel ? bop_r : gop_r;
    p   = cmd.sel ? par_rd_r[31:0] : par_rd_r[63:32];
    m   = mvld_r ? (cmd.sel ? mom_rd_r[63:32] : mom_rd_r[127:96]) : 32'sd0;
    v   = mvld_r ? (cmd.sel ? mom_rd_r[31:0] : mom_rd_r[95:64]) : 32'd0;
    gx  = {g[31], g};
    ag  = gx[32] ? -gx : gx;
    mnx = -{mn_r[31], mn_r};
    am  = mn_r[31] ? mnx[31:0] : mn_r[31:0];
    d1  = asu_pkg::ONE_Q31 - p1_r;
    d2  = asu_pkg::ONE_Q31 - p2_r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      asu_pkg::OP_PW1M: begin
        mul_a = {1'b0, p1_r};
        mul_b = {2'b00, asu_pkg::BETA1};
      end
      asu_pkg::OP_PW2M: begin
        mul_a = {1'b0, p2_r};
        mul_b = {2'b00, asu_pkg::BETA2};
      end
      asu_pkg::OP_SGDM: begin
        mul_a = {9'd0, cfg_lr};
        mul_b = gx;
      end
      asu_pkg::OP_M1: begin
        mul_a = {2'b00, asu_pkg::BETA1};
        mul_b = {m[31], m};
      end
      asu_pkg::OP_M2: begin
        mul_a = {1'b0, asu_pkg::OMB1};
        mul_b = gx;
      end
      asu_pkg::OP_SQM: begin
        mul_a = ag;
        mul_b = ag;
      end
      asu_pkg::OP_V1: begin
        mul_a = {2'b00, asu_pkg::BETA2};
        mul_b = {1'b0, v};
      end
      asu_pkg::OP_V2: begin
        mul_a = {1'b0, asu_pkg::OMB2};
        mul_b = {1'b0, sq_r};
      end
      asu_pkg::OP_STM: begin
        mul_a = {2'b00, mh_r};
        mul_b = {9'd0, cfg_lr};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    sum     = {acc_r[65], acc_r} + {prod_r[65], prod_r};
    sum_rnd = sum + 67'sd1073741824;
    m_sh    = sum_rnd >>> 31;
    if (!m_sh[66] && (|m_sh[65:31])) m_nxt = 32'sh7FFF_FFFF;
    else if (m_sh[66] && !(&m_sh[65:31])) m_nxt = 32'sh8000_0000;
    else m_nxt = m_sh[31:0];

    sq_t   = prod_r[62:0] + 63'd32768;
    sq_nxt = (|sq_t[62:48]) ? 32'hFFFF_FFFF : sq_t[47:16];

    v_nxt  = (|sum_rnd[66:63]) ? 32'hFFFF_FFFF : sum_rnd[62:31];

    if (d1 == 32'd0) mh_nxt = am[31] ? 31'h7FFF_FFFF : am[30:0];
    else if (div_ovf || (|div_quo[33:31])) mh_nxt = 31'h7FFF_FFFF;
    else mh_nxt = div_quo[30:0];

    if (d2 == 32'd0) vh_nxt = vn_r;
    else if (div_ovf || (|div_quo[33:32])) vh_nxt = 32'hFFFF_FFFF;
    else vh_nxt = div_quo[31:0];

    if (den_r == 41'd0 || mh_r == 31'd0) step = '0;
    else if (div_ovf || div_quo > asu_pkg::STEP_CAP) step = asu_pkg::STEP_CAP;
    else step = div_quo;
    pu_sum = mn_r[31] ? ({{3{p[31]}}, p} + {1'b0, step})
                      : ({{3{p[31]}}, p} - {1'b0, step});

    sgd_rnd = (prod_r + 66'sd8388608) >>> 24;
    sgd_sum = {{3{p[31]}}, p} - {sgd_rnd[33], sgd_rnd[33:0]};
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      asu_pkg::OP_DM: begin
        div_start = 1'b1;
        div_num   = {1'b0, am, 31'd0};
        div_den   = {9'd0, d1};
      end
      asu_pkg::OP_DV: begin
        div_start = 1'b1;
        div_num   = {1'b0, vn_r, 31'd0};
        div_den   = {9'd0, d2};
      end
      asu_pkg::OP_DS: begin
        div_start = 1'b1;
        div_num   = {prod_r[55:0], 8'd0};
        div_den   = den_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  asu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  asu_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == asu_pkg::OP_SQS),
    .rad   (vh_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      p1_r    <= asu_pkg::ONE_Q31;
      p2_r    <= asu_pkg::ONE_Q31;
    end else begin
      if (cmd.op == asu_pkg::OP_WBA) valid_r[addr_r] <= 1'b1;
      if (cmd.op == asu_pkg::OP_PW1U) p1_r <= sum_rnd[62:31];
      if (cmd.op == asu_pkg::OP_PW2U) p2_r <= sum_rnd[62:31];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r    <= in_feature_index;
      addr_r   <= in_addr;
      mode_r   <= in_mode;
      begin_r  <= in_begin_pass;
      rng_r    <= in_rng;
      gop_r    <= in_gamma_operand;
      bop_r    <= in_beta_operand;
      par_rd_r <= par_mem[in_addr];
      mom_rd_r <= mom_mem[in_addr];
      mvld_r   <= valid_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      asu_pkg::OP_WBL: par_mem[addr_r] <= {gop_r, bop_r};
      asu_pkg::OP_WBS: par_mem[addr_r] <= {pn_r[0], pn_r[1]};
      asu_pkg::OP_WBA: begin
        par_mem[addr_r] <= {pn_r[0], pn_r[1]};
        mom_mem[addr_r] <= {mw_r[0], vw_r[0], mw_r[1], vw_r[1]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      asu_pkg::OP_PW1M, asu_pkg::OP_PW2M: acc_r <= '0;
      asu_pkg::OP_M2, asu_pkg::OP_V2: acc_r <= prod_r;
      asu_pkg::OP_SGDU: pn_r[cmd.sel] <= sat35(sgd_sum);
      asu_pkg::OP_MU:   mn_r <= m_nxt;
      asu_pkg::OP_SQU:  sq_r <= sq_nxt;
      asu_pkg::OP_VU:   vn_r <= v_nxt;
      asu_pkg::OP_MHU:  mh_r <= mh_nxt;
      asu_pkg::OP_VHU:  vh_r <= vh_nxt;
      asu_pkg::OP_DENU: den_r <= {1'b0, sqrt_root, 8'd0} + {9'd0, cfg_eps};
      asu_pkg::OP_PU: begin
        pn_r[cmd.sel] <= sat35(pu_sum);
        mw_r[cmd.sel] <= mn_r;
        vw_r[cmd.sel] <= vn_r;
      end
      asu_pkg::OP_WBL: begin
        res_r[0] <= gop_r;
        res_r[1] <= bop_r;
      end
      asu_pkg::OP_WBS, asu_pkg::OP_WBA: begin
        res_r[0] <= pn_r[0];
        res_r[1] <= pn_r[1];
      end
      asu_pkg::OP_OUT: begin
        oidx_r <= idx_r;
        og_r   <= rng_r ? res_r[0] : 32'sd0;
        ob_r   <= rng_r ? res_r[1] : 32'sd0;
      end
      default: ;
    endcase
  end

  // power updates use the sum path with acc cleared, so sum_rnd is (p*beta + half) here
  assign sts.in_range   = rng_r;
  assign sts.mode       = mode_r;
  assign sts.begin_pass = begin_r;
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sqrt_done;

  assign out_index     = oidx_r;
  assign out_new_gamma = og_r;
  assign out_new_beta  = ob_r;

endmodule

// ===== design/asu_ctrl.sv =====
// Controller state machine: sequences the datapath per request and runs both handshakes.
// Depends on asu_pkg for state, command and status types.
module asu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          opt_sel,
  input  asu_pkg::sts_t sts,
  output asu_pkg::cmd_t cmd
);

  asu_pkg::state_t state_r, state_nxt;
  logic            sel_r, sel_nxt;
  logic            out_valid_r;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      asu_pkg::S_IDLE: if (in_valid) state_nxt = asu_pkg::S_DISP;
      asu_pkg::S_DISP: begin
        sel_nxt = 1'b0;
        if (!sts.in_range) state_nxt = asu_pkg::S_OUT;
        else if (sts.mode) state_nxt = asu_pkg::S_WBL;
        else if (!opt_sel) state_nxt = asu_pkg::S_SGDM;
        else if (sts.begin_pass) state_nxt = asu_pkg::S_PW1M;
        else state_nxt = asu_pkg::S_M1;
      end
      asu_pkg::S_PW1M: state_nxt = asu_pkg::S_PW1U;
      asu_pkg::S_PW1U: state_nxt = asu_pkg::S_PW2M;
      asu_pkg::S_PW2M: state_nxt = asu_pkg::S_PW2U;
      asu_pkg::S_PW2U: state_nxt = asu_pkg::S_M1;
      asu_pkg::S_SGDM: state_nxt = asu_pkg::S_SGDU;
      asu_pkg::S_SGDU: begin
        sel_nxt   = 1'b1;
        state_nxt = sel_r ? asu_pkg::S_WBS : asu_pkg::S_SGDM;
      end
      asu_pkg::S_M1:   state_nxt = asu_pkg::S_M2;
      asu_pkg::S_M2:   state_nxt = asu_pkg::S_MU;
      asu_pkg::S_MU:   state_nxt = asu_pkg::S_SQM;
      asu_pkg::S_SQM:  state_nxt = asu_pkg::S_SQU;
      asu_pkg::S_SQU:  state_nxt = asu_pkg::S_V1;
      asu_pkg::S_V1:   state_nxt = asu_pkg::S_V2;
      asu_pkg::S_V2:   state_nxt = asu_pkg::S_VU;
      asu_pkg::S_VU:   state_nxt = asu_pkg::S_DM;
      asu_pkg::S_DM:   state_nxt = asu_pkg::S_DMW;
      asu_pkg::S_DMW:  if (sts.div_done) state_nxt = asu_pkg::S_MHU;
      asu_pkg::S_MHU:  state_nxt = asu_pkg::S_DV;
      asu_pkg::S_DV:   state_nxt = asu_pkg::S_DVW;
      asu_pkg::S_DVW:  if (sts.div_done) state_nxt = asu_pkg::S_VHU;
      asu_pkg::S_VHU:  state_nxt = asu_pkg::S_SQS;
      asu_pkg::S_SQS:  state_nxt = asu_pkg::S_SQW;
      asu_pkg::S_SQW:  if (sts.sqrt_done) state_nxt = asu_pkg::S_DENU;
      asu_pkg::S_DENU: state_nxt = asu_pkg::S_STM;
      asu_pkg::S_STM:  state_nxt = asu_pkg::S_DS;
      asu_pkg::S_DS:   state_nxt = asu_pkg::S_DSW;
      asu_pkg::S_DSW:  if (sts.div_done) state_nxt = asu_pkg::S_PU;
      asu_pkg::S_PU: begin
        sel_nxt   = 1'b1;
        state_nxt = sel_r ? asu_pkg::S_WBA : asu_pkg::S_M1;
      end
      asu_pkg::S_WBL, asu_pkg::S_WBS, asu_pkg::S_WBA: state_nxt = asu_pkg::S_OUT;
      asu_pkg::S_OUT:  if (out_free) state_nxt = asu_pkg::S_IDLE;
      default:         state_nxt = asu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.sel      = sel_r;
    cmd.capture  = (state_r == asu_pkg::S_IDLE) && in_valid;
    cmd.out_load = (state_r == asu_pkg::S_OUT) && out_free;
    in_ready     = (state_r == asu_pkg::S_IDLE);
    case (state_r)
      asu_pkg::S_PW1M: cmd.op = asu_pkg::OP_PW1M;
      asu_pkg::S_PW1U: cmd.op = asu_pkg::OP_PW1U;
      asu_pkg::S_PW2M: cmd.op = asu_pkg::OP_PW2M;
      asu_pkg::S_PW2U: cmd.op = asu_pkg::OP_PW2U;
      asu_pkg::S_SGDM: cmd.op = asu_pkg::OP_SGDM;
      asu_pkg::S_SGDU: cmd.op = asu_pkg::OP_SGDU;
      asu_pkg::S_M1:   cmd.op = asu_pkg::OP_M1;
      asu_pkg::S_M2:   cmd.op = asu_pkg::OP_M2;
      asu_pkg::S_MU:   cmd.op = asu_pkg::OP_MU;
      asu_pkg::S_SQM:  cmd.op = asu_pkg::OP_SQM;
      asu_pkg::S_SQU:  cmd.op = asu_pkg::OP_SQU;
      asu_pkg::S_V1:   cmd.op = asu_pkg::OP_V1;
      asu_pkg::S_V2:   cmd.op = asu_pkg::OP_V2;
      asu_pkg::S_VU:   cmd.op = asu_pkg::OP_VU;
      asu_pkg::S_DM:   cmd.op = asu_pkg::OP_DM;
      asu_pkg::S_MHU:  cmd.op = asu_pkg::OP_MHU;
      asu_pkg::S_DV:   cmd.op = asu_pkg::OP_DV;
      asu_pkg::S_VHU:  cmd.op = asu_pkg::OP_VHU;
      asu_pkg::S_SQS:  cmd.op = asu_pkg::OP_SQS;
      asu_pkg::S_DENU: cmd.op = asu_pkg::OP_DENU;
      asu_pkg::S_STM:  cmd.op = asu_pkg::OP_STM;
      asu_pkg::S_DS:   cmd.op = asu_pkg::OP_DS;
      asu_pkg::S_PU:   cmd.op = asu_pkg::OP_PU;
      asu_pkg::S_WBL:  cmd.op = asu_pkg::OP_WBL;
      asu_pkg::S_WBS:  cmd.op = asu_pkg::OP_WBS;
      asu_pkg::S_WBA:  cmd.op = asu_pkg::OP_WBA;
      asu_pkg::S_OUT:  cmd.op = out_free ? asu_pkg::OP_OUT : asu_pkg::OP_NONE;
      default:         cmd.op = asu_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asu_pkg::S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/adam_sgd_parameter_update.sv =====
// Top level: configuration registers, controller and datapath of the optimizer block.
// Depends on asu_pkg, asu_ctrl and asu_dp.
//
//  port group | direction | handshake        | contents
//  in_*       | request   | in_valid/ready   | mode, feature index, begin_pass, two operands
//  out_*      | result    | out_valid/ready  | index, new gamma, new beta
//  APB        | config    | psel/penable     | optimizer_select, step_size, epsilon
//
// One request at a time; an Adam request runs the shared divider (34 steps, three runs
// per parameter) and the root unit (32 steps), and first advances the bias-correction
// powers when begin_pass is set; load, SGD and out-of-range requests use neither unit.
// Reset is synchronous; moments clear through per-feature valid bits, no sweep.
// A finished result waits in the output register while the next request is taken; the
// controller holds in its last state while that register still holds an unread result.
module adam_sgd_parameter_update #(
  parameter int unsigned FEATURE_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_feature_index,
  input  logic               in_begin_pass,
  input  logic signed [31:0] in_gamma_operand,
  input  logic signed [31:0] in_beta_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_index,
  output logic signed [31:0] out_new_gamma,
  output logic signed [31:0] out_new_beta,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          opt_r;
  logic [23:0]   lr_r;
  logic [31:0]   eps_r;
  logic          wr_en;
  asu_pkg::cmd_t cmd;
  asu_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opt_r <= 1'b1;
      lr_r  <= asu_pkg::RST_LR;
      eps_r <= asu_pkg::RST_EPS;
    end else if (wr_en) begin
      case (paddr[3:2])
        asu_pkg::REG_OPT: opt_r <= pwdata[0];
        asu_pkg::REG_LR:  lr_r  <= pwdata[23:0];
        asu_pkg::REG_EPS: eps_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      asu_pkg::REG_OPT: prdata = {31'd0, opt_r};
      asu_pkg::REG_LR:  prdata = {8'd0, lr_r};
      asu_pkg::REG_EPS: prdata = eps_r;
      default:          prdata = '0;
    endcase
  end

  asu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .opt_sel   (opt_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  asu_dp #(
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_feature_index (in_feature_index),
    .in_begin_pass    (in_begin_pass),
    .in_gamma_operand (in_gamma_operand),
    .in_beta_operand  (in_beta_operand),
    .cfg_lr           (lr_r),
    .cfg_eps          (eps_r),
    .out_index        (out_index),
    .out_new_gamma    (out_new_gamma),
    .out_new_beta     (out_new_beta)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for adam_sgd_parameter_update: load, SGD and Adam requests
// against a bit-exact fixed-point predictor. Depends on asu_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] gam;
    logic [31:0] bet;
  } param_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [7:0] in_feature_index = '0;
  logic in_begin_pass = 1'b0;
  logic signed [31:0] in_gamma_operand = '0;
  logic signed [31:0] in_beta_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_index;
  logic signed [31:0] out_new_gamma;
  logic signed [31:0] out_new_beta;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  adam_sgd_parameter_update DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic signed [31:0] gam_mem [256];
  logic signed [31:0] bet_mem [256];
  logic signed [31:0] m_gam [256];
  logic signed [31:0] m_bet [256];
  logic [31:0] v_gam [256];
  logic [31:0] v_bet [256];
  bit written [256];
  logic [31:0] pow1, pow2;
  logic opt_sel;
  logic [23:0] lr_q24;
  logic [31:0] eps_q32;

  param_rsp_t expected_params[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  function automatic logic signed [31:0] sat32(logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic adam_param(inout logic signed [31:0] p, inout logic signed [31:0] m,
                            inout logic [31:0] v, input logic signed [31:0] g);
    logic signed [95:0] mn;
    logic [63:0] ag, sq, am, vh, den, step;
    logic [127:0] vn, num;
    logic neg;
    mn = 96'(signed'({1'b0, asu_pkg::BETA1})) * m + 96'(signed'(asu_pkg::OMB1)) * g +
         (96'sd1 <<< 30);
    m = sat32(66'(mn >>> 31));
    ag = g < 0 ? 64'(-65'(g)) : 64'(g);
    sq = (ag * ag + (64'd1 << 15)) >> 16;
    if (sq > 64'hFFFFFFFF) sq = 64'hFFFFFFFF;
    vn = (128'(asu_pkg::BETA2) * v + 128'(asu_pkg::OMB2) * sq + (128'd1 << 30)) >> 31;
    v = vn > 128'hFFFFFFFF ? 32'hFFFFFFFF : vn[31:0];
    neg = m < 0;
    am = neg ? 64'(-65'(m)) : 64'(m);
    if (pow1 != asu_pkg::ONE_Q31) am = (am << 31) / (asu_pkg::ONE_Q31 - pow1);
    if (am > 64'h7FFFFFFF) am = 64'h7FFFFFFF;
    vh = v;
    if (pow2 != asu_pkg::ONE_Q31) vh = (vh << 31) / (asu_pkg::ONE_Q31 - pow2);
    if (vh > 64'hFFFFFFFF) vh = 64'hFFFFFFFF;
    den = (isqrt(vh << 32) << 8) + eps_q32;
    step = 0;
    if (den != 0 && am != 0) begin
      num = (128'(am) * lr_q24) << 8;
      num = num / den;
      step = num > 128'(asu_pkg::STEP_CAP) ? 64'(asu_pkg::STEP_CAP) : num[63:0];
    end
    p = sat32(66'(p) - (neg ? -66'(step) : 66'(step)));
  endtask

  task automatic predict_params(input logic md, input logic [7:0] ix, input logic bp,
                                input logic signed [31:0] ga, input logic signed [31:0] be);
    logic signed [63:0] s;
    param_rsp_t r;
    r.idx = ix;
    if (md) begin
      gam_mem[ix] = ga;
      bet_mem[ix] = be;
      written[ix] = 1'b1;
    end else if (!opt_sel) begin
      s = (64'(signed'({1'b0, lr_q24})) * ga + (64'sd1 <<< 23)) >>> 24;
      gam_mem[ix] = sat32(66'(gam_mem[ix]) - s);
      s = (64'(signed'({1'b0, lr_q24})) * be + (64'sd1 <<< 23)) >>> 24;
      bet_mem[ix] = sat32(66'(bet_mem[ix]) - s);
    end else begin
      if (bp) begin
        pow1 = 32'((64'(pow1) * asu_pkg::BETA1 + (64'd1 << 30)) >> 31);
        pow2 = 32'((64'(pow2) * asu_pkg::BETA2 + (64'd1 << 30)) >> 31);
      end
      adam_param(gam_mem[ix], m_gam[ix], v_gam[ix], ga);
      adam_param(bet_mem[ix], m_bet[ix], v_bet[ix], be);
    end
    r.gam = gam_mem[ix];
    r.bet = bet_mem[ix];
    expected_params.push_back(r);
  endtask

  task automatic send_request(input logic md, input logic [7:0] ix, input logic bp,
                              input logic signed [31:0] ga, input logic signed [31:0] be);
    if (!md && !written[ix]) md = 1'b1;
    if (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 8) @(posedge clk);
    end
    predict_params(md, ix, bp, ga, be);
    in_valid <= 1'b1;
    in_mode <= md;
    in_feature_index <= ix;
    in_begin_pass <= bp;
    in_gamma_operand <= ga;
    in_beta_operand <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (expected_params.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      asu_pkg::REG_OPT: opt_sel = val[0];
      asu_pkg::REG_LR:  lr_q24 = val[23:0];
      default:          eps_q32 = val;
    endcase
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(4))
      0: return $urandom_range(131072) - 65536;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!no_idle) out_ready <= $urandom_range(99) >= 8;
    else out_ready <= 1'b1;
    if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_params.size() == 0) begin
        $error("unexpected result for index %0d", out_index);
        errors++;
      end else begin
        param_rsp_t e;
        e = expected_params.pop_front();
        if (out_index !== e.idx) begin
          $error("out_index expected %0d got %0d", e.idx, out_index);
          errors++;
        end
        if (out_new_gamma !== e.gam) begin
          $error("new_gamma expected %h got %h", e.gam, out_new_gamma);
          errors++;
        end
        if (out_new_beta !== e.bet) begin
          $error("new_beta expected %h got %h", e.bet, out_new_beta);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(1'b1, 8'd0, 1'b1, 32'h7FFFFFFF, 32'h80000000);
    send_request(1'b1, 8'd255, 1'b0, 32'h00010000, -32'sh00010000);
    send_request(1'b0, 8'd0, 1'b0, 32'h00010000, 32'h00010000);
    send_request(1'b0, 8'd255, 1'b1, 32'h7FFFFFFF, 32'h80000000);
    send_request(1'b0, 8'd0, 1'b1, 32'h80000000, 32'h7FFFFFFF);
    send_request(1'b0, 8'd255, 1'b0, 32'h0, 32'h0);
    write_reg(asu_pkg::REG_OPT, 32'd0);
    send_request(1'b0, 8'd0, 1'b1, 32'h80000000, 32'h7FFFFFFF);
    send_request(1'b0, 8'd255, 1'b0, 32'hFFFFFFFF, 32'h00000001);
    write_reg(asu_pkg::REG_LR, 32'hFFFFFF);
    send_request(1'b0, 8'd0, 1'b0, 32'h80000000, 32'h7FFFFFFF);
    send_request(1'b1, 8'd1, 1'b0, 32'h0, 32'h0);
    write_reg(asu_pkg::REG_OPT, 32'd1);
    write_reg(asu_pkg::REG_EPS, 32'd0);
    send_request(1'b0, 8'd1, 1'b0, 32'h0, 32'h0);
    send_request(1'b0, 8'd1, 1'b1, 32'h00001000, -32'sh00001000);
    write_reg(asu_pkg::REG_EPS, 32'hFFFFFFFF);
    write_reg(asu_pkg::REG_LR, 32'd0);
    send_request(1'b0, 8'd1, 1'b0, 32'h7FFFFFFF, 32'h80000000);
  endtask

  task automatic test_random(input int count, input logic [23:0] lr, input logic [31:0] eps,
                             input logic sel);
    int k;
    write_reg(asu_pkg::REG_LR, lr);
    write_reg(asu_pkg::REG_EPS, eps);
    write_reg(asu_pkg::REG_OPT, sel);
    for (k = 0; k < count; k++)
      send_request($urandom_range(9) == 0, 8'($urandom_range(15) == 0 ? $urandom
                   : $urandom_range(7)), $urandom_range(7) == 0, rand_operand(),
                   rand_operand());
  endtask

  initial begin
    int i;
    for (i = 0; i < 256; i++) begin
      gam_mem[i] = 0; bet_mem[i] = 0; m_gam[i] = 0; m_bet[i] = 0;
      v_gam[i] = 0; v_bet[i] = 0; written[i] = 1'b0;
    end
    pow1 = asu_pkg::ONE_Q31;
    pow2 = asu_pkg::ONE_Q31;
    opt_sel = 1'b1;
    lr_q24 = asu_pkg::RST_LR;
    eps_q32 = asu_pkg::RST_EPS;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250, 24'd16777, 32'd43, 1'b0);
    test_random(300, 24'd16777, 32'd43, 1'b1);
    no_idle = 1'b1;
    test_random(150, 24'h800000, 32'd0, 1'b1);
    no_idle = 1'b0;
    test_random(250, $urandom, $urandom, $urandom_range(1));
    in_valid <= 1'b0;
    while (expected_params.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
